// ----- rtl/assert_macros.svh -----
// Assertion macros used by the deframer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while in reset
`define APDF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define APDF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/apdf_pkg.sv -----
// Package for the addressed packet deframer: types, codes and constants
package apdf_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int PLEN_W      = 6;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;

	localparam logic [BYTE_W-1:0] MIN_LEN = 8'd3;

	// Status codes
	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD_CRC = 2'd1;
	localparam logic [1:0] ST_NOT_ADR = 2'd2;
	localparam logic [1:0] ST_FAIL    = 2'd3;

	// Item kinds
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIMPLEX_MODE = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_fail;
	} in_item_t;

	typedef struct packed {
		logic              item_kind;
		logic [1:0]        status;
		logic              reply_due;
		logic [PLEN_W-1:0] payload_length;
		logic [BYTE_W-1:0] payload_byte;
		logic              last;
	} out_item_t;

	typedef enum logic {
		S_RX,
		S_PAY
	} state_t;

endpackage

// ----- rtl/apdf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
module apdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/addressed_packet_deframer_core.sv -----
// Addressed packet deframer: frames received bytes, checks id, length and XOR, replays payload
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | in_data  (rx_byte, rx_fail)
//  out     | output    | out_valid / out_ready| out_data (kind, status, reply, ...)
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// Receive: one byte a cycle while in_ready is high; each byte without rx_fail is written
// into the payload RAM at its position. A good packet with N payload bytes then replays
// one RAM read a cycle while the output register is free; in_ready stays low until the
// last payload transaction is loaded. Every status and payload item passes through one
// output register; out_ready low stalls the replay, and in_ready follows the output
// register being free. Reset clears the packet counters and config; the RAM is not cleared.
`include "assert_macros.svh"

module addressed_packet_deframer_core
	import apdf_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata
);

	localparam int PW = $clog2(MAX_LEN);

	// Configuration
	logic [BYTE_W-1:0] device_id_q;
	logic [BYTE_W-1:0] broadcast_id_q;
	logic              simplex_q;

	// Packet state
	state_t            state_q, state_d;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     explen_q;
	logic [BYTE_W-1:0] xor_q;
	logic              bcast_q;

	// Replay state
	logic [PW-1:0]     rd_addr_q;
	logic [PW-1:0]     rd_left_q;
	logic              pend_s1;
	logic              pend_last_s1;

	// Output register
	logic              out_valid_q;
	out_item_t         out_q;

	// Combinational
	logic              accept;
	logic              out_free;
	logic              id_miss;
	logic              len_bad;
	logic              pkt_done;
	logic [BYTE_W-1:0] xor_next;
	logic [PW-1:0]     plen;
	logic              pkt_end;
	logic              go_replay;
	out_item_t         stat_item;
	out_item_t         pay_item;
	logic              load_stat;
	logic              load_pay;
	logic              rd_en;
	logic              ram_we;
	logic [BYTE_W-1:0] ram_rdata;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q    <= '0;
			broadcast_id_q <= '0;
			simplex_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ID:    device_id_q    <= cfg_wdata;
				CFG_BROADCAST_ID: broadcast_id_q <= cfg_wdata;
				CFG_SIMPLEX_MODE: simplex_q      <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// Byte decode
	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign id_miss  = (pos_q == '0) && (in_data.rx_byte != device_id_q)
		&& (in_data.rx_byte != broadcast_id_q);
	assign len_bad  = (pos_q == PW'(1)) && ((in_data.rx_byte < MIN_LEN)
		|| ({1'b0, in_data.rx_byte} >= 9'(MAX_LEN)));
	// expected length is only meaningful from position 2 onwards
	assign pkt_done = (pos_q >= PW'(2)) && (pos_q == PW'(explen_q - PW'(1)));
	assign xor_next = xor_q ^ in_data.rx_byte;
	assign plen     = PW'(explen_q - PW'(3));
	assign pkt_end  = in_data.rx_fail || id_miss || len_bad || pkt_done;

	// Status item for the current byte
	always_comb begin
		stat_item           = '0;
		stat_item.item_kind = KIND_STATUS;
		stat_item.last      = 1'b1;
		if (in_data.rx_fail || len_bad) begin
			stat_item.status = ST_FAIL;
		end else if (id_miss) begin
			stat_item.status = ST_NOT_ADR;
		end else if (xor_next != '0) begin
			stat_item.status    = ST_BAD_CRC;
			stat_item.reply_due = !bcast_q && !simplex_q;
		end else begin
			stat_item.status         = ST_GOOD;
			stat_item.reply_due      = !bcast_q && !simplex_q;
			stat_item.payload_length = PLEN_W'(plen);
			stat_item.last           = (plen == '0);
		end
	end

	// Payload item from the RAM read data
	always_comb begin
		pay_item              = '0;
		pay_item.item_kind    = KIND_PAYLOAD;
		pay_item.payload_byte = ram_rdata;
		pay_item.last         = pend_last_s1;
	end

	// FSM outputs
	always_comb begin
		in_ready  = (state_q == S_RX) && out_free;
		load_stat = accept && pkt_end;
		go_replay = accept && !in_data.rx_fail && pkt_done && (xor_next == '0)
			&& (plen != '0);
		load_pay  = (state_q == S_PAY) && pend_s1 && out_free;
		rd_en     = (state_q == S_PAY) && (rd_left_q != '0) && (!pend_s1 || load_pay);
		ram_we    = accept && !in_data.rx_fail;
	end

	// FSM next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_RX: begin
				if (go_replay) begin
					state_d = S_PAY;
				end
			end
			S_PAY: begin
				if (load_pay && pend_last_s1) begin
					state_d = S_RX;
				end
			end
			default: state_d = S_RX;
		endcase
	end

	// Packet counters and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RX;
			pos_q    <= '0;
			explen_q <= '0;
			xor_q    <= '0;
			bcast_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (pkt_end) begin
					pos_q   <= '0;
					xor_q   <= '0;
					bcast_q <= 1'b0;
				end else begin
					pos_q <= PW'(pos_q + PW'(1));
					xor_q <= xor_next;
					if (pos_q == '0) begin
						bcast_q <= (in_data.rx_byte == broadcast_id_q);
					end
					if (pos_q == PW'(1)) begin
						explen_q <= in_data.rx_byte[PW-1:0];
					end
				end
			end
		end
	end

	// Replay read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q    <= '0;
			rd_left_q    <= '0;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
		end else begin
			if (go_replay) begin
				rd_addr_q <= PW'(2);
				rd_left_q <= plen;
			end else if (rd_en) begin
				rd_addr_q <= PW'(rd_addr_q + PW'(1));
				rd_left_q <= PW'(rd_left_q - PW'(1));
			end
			if (rd_en) begin
				pend_s1      <= 1'b1;
				pend_last_s1 <= (rd_left_q == PW'(1));
			end else if (load_pay) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_stat || load_pay) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_stat) begin
			out_q <= stat_item;
		end else if (load_pay) begin
			out_q <= pay_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Payload store; writes only while receiving, reads only during replay
	apdf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_LEN)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (in_data.rx_byte),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// Checks
	`APDF_ASSERT(a_no_rx_in_replay, (state_q == S_PAY) |-> !in_ready, "input taken during replay")
	`APDF_ASSERT(a_pend_in_replay, pend_s1 |-> (state_q == S_PAY), "read pending outside replay")
	`APDF_ASSERT(a_left_in_replay, (rd_left_q != '0) |-> (state_q == S_PAY), "reads left in receive")
	`APDF_ASSERT(a_last_ends_replay, load_pay && pend_last_s1 |=> state_q == S_RX, "replay stuck")
	`APDF_ASSERT_ALWAYS(a_single_load, !(load_stat && load_pay), "status and payload loaded together")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the addressed packet deframer core
`timescale 1ns / 1ps

module tb;
	import apdf_pkg::*;

	localparam int PKT_MAX        = MAX_LEN_DEF;
	localparam int PHASE_ITEMS    = 40;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DEVICE_ID;
	logic [BYTE_W-1:0]    cfg_wdata = '0;

	// Predictor copy of the registers and packet state
	logic [BYTE_W-1:0] own_id   = '0;
	logic [BYTE_W-1:0] bcast_id = '0;
	logic              no_reply = 1'b0;
	logic [PLEN_W-1:0] rx_pos   = '0;
	int                rx_len   = PKT_MAX;
	logic [BYTE_W-1:0] rx_xor   = '0;
	logic              rx_bcast = 1'b0;
	logic [BYTE_W-1:0] rx_store [PKT_MAX];

	out_item_t step_out [$];
	out_item_t deframed_q [$];
	dir_row_t  directed_rows [$];

	// Directed rows may carry a hand-typed expectation
	bit        row_typed = 1'b0;
	out_item_t row_want  = '0;

	int  in_idle_pct  = 6;
	int  out_idle_pct = 53;
	bit  stall_req    = 1'b0;
	int  rx_sent      = 0;
	int  fail_count   = 0;
	int  quiet_cycles = 0;

	addressed_packet_deframer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic in_item_t rx_item(input logic [7:0] b, input logic f);
		in_item_t it;
		it.rx_byte = b;
		it.rx_fail = f;
		return it;
	endfunction

	// Single terminal status item
	function automatic out_item_t status_item(input logic [1:0] st, input logic reply,
			input logic [PLEN_W-1:0] plen);
		out_item_t r;
		r                = '0;
		r.item_kind      = KIND_STATUS;
		r.status         = st;
		r.reply_due      = reply;
		r.payload_length = plen;
		r.last           = 1'b1;
		return r;
	endfunction

	function automatic void add_row(input in_item_t stim, input bit typed,
			input out_item_t want);
		dir_row_t row;
		row.stim  = stim;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	function automatic void clear_rx();
		rx_pos   = '0;
		rx_len   = PKT_MAX;
		rx_xor   = '0;
		rx_bcast = 1'b0;
	endfunction

	// Deframe one received byte; results go to step_out
	function automatic void deframe_step(input in_item_t it);
		out_item_t         r;
		logic              reply;
		logic [PLEN_W-1:0] plen;
		r = '0;
		if (it.rx_fail) begin
			step_out.push_back(status_item(ST_FAIL, 1'b0, '0));
			clear_rx();
			return;
		end
		if (rx_pos == 0) begin
			if (it.rx_byte != own_id && it.rx_byte != bcast_id) begin
				step_out.push_back(status_item(ST_NOT_ADR, 1'b0, '0));
				clear_rx();
				return;
			end
			rx_bcast = (it.rx_byte == bcast_id);
		end else if (rx_pos == 1) begin
			if (it.rx_byte < MIN_LEN || int'(it.rx_byte) >= PKT_MAX) begin
				step_out.push_back(status_item(ST_FAIL, 1'b0, '0));
				clear_rx();
				return;
			end
			rx_len = int'(it.rx_byte);
		end
		rx_store[rx_pos] = it.rx_byte;
		rx_xor           = rx_xor ^ it.rx_byte;
		rx_pos           = rx_pos + PLEN_W'(1);
		if (int'(rx_pos) < rx_len)
			return;

		reply = !rx_bcast && !no_reply;
		if (rx_xor != 0) begin
			step_out.push_back(status_item(ST_BAD_CRC, reply, '0));
			clear_rx();
			return;
		end
		plen             = PLEN_W'(rx_len - 3);
		r                = status_item(ST_GOOD, reply, plen);
		r.last           = (plen == 0);
		step_out.push_back(r);
		for (int i = 0; i < int'(plen); i++) begin
			r              = '0;
			r.item_kind    = KIND_PAYLOAD;
			r.payload_byte = rx_store[i + 2];
			r.last         = (i == int'(plen) - 1);
			step_out.push_back(r);
		end
		clear_rx();
	endfunction

	task automatic check_field(input string fname, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			fail_count++;
		end
	endtask

	// Monitor: register writes, output checks, then input predictions
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEVICE_ID:    own_id = cfg_wdata;
					CFG_BROADCAST_ID: bcast_id = cfg_wdata;
					CFG_SIMPLEX_MODE: no_reply = cfg_wdata[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (deframed_q.size() == 0) begin
					$error("unexpected result transaction %h", out_data);
					fail_count++;
				end else begin
					want = deframed_q.pop_front();
					check_field("item_kind", int'(want.item_kind), int'(out_data.item_kind));
					check_field("status", int'(want.status), int'(out_data.status));
					check_field("reply_due", int'(want.reply_due), int'(out_data.reply_due));
					check_field("payload_length", int'(want.payload_length),
						int'(out_data.payload_length));
					check_field("payload_byte", int'(want.payload_byte),
						int'(out_data.payload_byte));
					check_field("last", int'(want.last), int'(out_data.last));
				end
			end
			if (in_valid && in_ready) begin
				step_out.delete();
				deframe_step(in_data);
				if (row_typed)
					deframed_q.push_back(row_want);
				else
					foreach (step_out[i]) deframed_q.push_back(step_out[i]);
			end
		end
	end

	// Watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL addressed_packet_deframer_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(negedge clk);
				stall_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// Offer one transaction; called and returns at a falling edge
	task automatic push_rx(input in_item_t it, input bit typed, input out_item_t want);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		row_typed = typed;
		row_want  = want;
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rx_sent++;
		@(negedge clk);
	endtask

	// Sender pauses until every expected result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (deframed_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] dev, input logic [7:0] bc,
			input logic simplex);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEVICE_ID;
		cfg_wdata <= dev;
		@(negedge clk);
		cfg_index <= CFG_BROADCAST_ID;
		cfg_wdata <= bc;
		@(negedge clk);
		cfg_index <= CFG_SIMPLEX_MODE;
		cfg_wdata <= {7'd0, simplex};
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic rx(input logic [7:0] b, input logic f);
		push_rx(rx_item(b, f), 1'b0, '0);
	endtask

	// One random packet: mostly well-formed, the rest noise that resyncs the framer
	task automatic send_packet();
		logic [7:0] pkt [PKT_MAX];
		logic [7:0] acc;
		int         sel;
		int         len;
		int         cut;
		sel = $urandom_range(99);
		if (sel < 72) begin
			sel = $urandom_range(99);
			if (sel < 8)
				len = PKT_MAX - 1;
			else if (sel < 16)
				len = $urandom_range(13, PKT_MAX - 1);
			else
				len = $urandom_range(3, 12);
			pkt[0] = $urandom_range(1) ? own_id : bcast_id;
			pkt[1] = 8'(len);
			acc    = pkt[0] ^ pkt[1];
			for (int i = 2; i < len - 1; i++) begin
				pkt[i] = 8'($urandom_range(255));
				acc    = acc ^ pkt[i];
			end
			pkt[len - 1] = acc;
			if ($urandom_range(99) < 15)
				pkt[len - 1] = acc ^ (8'h01 << $urandom_range(7));
			cut = ($urandom_range(99) < 6) ? $urandom_range(1, len - 1) : len;
			for (int i = 0; i < cut; i++) rx(pkt[i], 1'b0);
			if (cut < len)
				rx(8'($urandom_range(255)), 1'b1);
		end else if (sel < 80) begin
			rx(8'($urandom_range(255)), 1'b1);
		end else if (sel < 88) begin
			// stray byte; if it happens to match an id, abort right after
			pkt[0] = 8'($urandom_range(255));
			rx(pkt[0], 1'b0);
			if (pkt[0] == own_id || pkt[0] == bcast_id)
				rx(8'($urandom_range(255)), 1'b1);
		end else begin
			rx($urandom_range(1) ? own_id : bcast_id, 1'b0);
			rx(8'(($urandom_range(3) == 0) ? $urandom_range(2)
				: $urandom_range(PKT_MAX, 255)), 1'b0);
		end
	endtask

	// Main sequence
	initial begin
		int start;

		// no match, bad lengths, empty good packet, bad checksum, aborts
		add_row(rx_item(8'hA5, 1'b1), 1'b1, status_item(ST_FAIL, 1'b0, '0));
		add_row(rx_item(8'h00, 1'b0), 1'b1, status_item(ST_NOT_ADR, 1'b0, '0));
		add_row(rx_item(8'h5B, 1'b0), 1'b1, status_item(ST_NOT_ADR, 1'b0, '0));
		add_row(rx_item(8'h5A, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h02, 1'b0), 1'b1, status_item(ST_FAIL, 1'b0, '0));
		add_row(rx_item(8'h5A, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h40, 1'b0), 1'b1, status_item(ST_FAIL, 1'b0, '0));
		add_row(rx_item(8'h5A, 1'b0), 1'b0, '0);
		add_row(rx_item(8'hFF, 1'b0), 1'b1, status_item(ST_FAIL, 1'b0, '0));
		add_row(rx_item(8'h5A, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h03, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h59, 1'b0), 1'b1, status_item(ST_GOOD, 1'b1, '0));
		add_row(rx_item(8'h5A, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h03, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h00, 1'b0), 1'b1, status_item(ST_BAD_CRC, 1'b1, '0));
		// broadcast with two payload bytes
		add_row(rx_item(8'hFF, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h05, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h00, 1'b0), 1'b0, '0);
		add_row(rx_item(8'hFF, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h05, 1'b0), 1'b0, '0);
		// sync failure mid packet
		add_row(rx_item(8'h5A, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h06, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h12, 1'b0), 1'b0, '0);
		add_row(rx_item(8'h00, 1'b1), 1'b1, status_item(ST_FAIL, 1'b0, '0));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		apply_settings(8'h5A, 8'hFF, 1'b0);
		foreach (directed_rows[i])
			push_rx(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: apply_settings(8'h00, 8'hFF, 1'b0);
				1: apply_settings(8'hFF, 8'h00, 1'b1);
				2: begin
					start = $urandom_range(255);
					apply_settings(8'(start), 8'(start), 1'b0);
				end
				3: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				4: apply_settings(8'h80, 8'h7F, 1'b1);
				default: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					1'b0);
			endcase
			if (phase < 2) begin
				in_idle_pct  = 6;
				out_idle_pct = 53;
			end else if (phase < 4) begin
				in_idle_pct  = 53;
				out_idle_pct = 6;
			end else begin
				in_idle_pct  = 0;
				out_idle_pct = 0;
			end
			// long receiver hold-off while the sender keeps pushing
			if (phase == 5)
				stall_req = 1'b1;
			start = rx_sent;
			while (rx_sent - start < PHASE_ITEMS) send_packet();
		end

		drain();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && deframed_q.size() == 0)
			$display("PASS addressed_packet_deframer_core");
		else
			$display("FAIL addressed_packet_deframer_core");
		$finish;
	end

endmodule
